/* rtl/wocf_pkg.sv */
`timescale 1ns / 1ps
package wocf_pkg;

    localparam int WT_FRAC = 16;
    localparam int WT_BITS = 40;
    localparam logic [22:0] THR_RESET = 23'd3276800;
    localparam logic [39:0] WT_ONE = 40'h00_0001_0000;
    localparam logic [39:0] WT_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] OUT48 = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [23:0] MAG_POS_LIM = 24'h7F_FFFF;
    localparam logic [23:0] MAG_NEG_LIM = 24'h80_0000;

    typedef struct packed {
        logic signed [23:0] obs_mag;
        logic signed [23:0] ref_mag;
        logic [23:0]        mag_error;
        logic               last_filter;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] offset;
        logic [47:0]        chi_square;
        logic [7:0]         used_filters;
        logic               no_data;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_WDIV_GO, S_WDIV_WAIT, S_WSET,
        S_MSQ_GO, S_MSQ_WAIT, S_ACC_SQ, S_MDF_GO, S_MDF_WAIT, S_ACC_DF,
        S_LAST_CHK, S_FDIV_GO, S_FDIV_WAIT, S_FMAG,
        S_MB_GO, S_MB_WAIT, S_BSET, S_MC_GO, S_MC_WAIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {MUL_SQ, MUL_DF, MUL_B, MUL_C} t_mul_sel;
    typedef enum logic {DIV_W, DIV_FIT} t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     prep;
        logic     div_start;
        t_div_sel div_sel;
        logic     set_w;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     acc_sq;
        logic     acc_df;
        logic     fin_mag;
        logic     set_b;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic err_zero;
        logic last;
        logic no_data;
        logic mul_busy;
        logic div_busy;
    } t_sts;

endpackage

/* rtl/wocf_ctrl.sv */
`timescale 1ns / 1ps
module wocf_ctrl
    import wocf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_PREP;
            S_PREP: begin
                if (i_sts.skip) n_state = S_LAST_CHK;
                else if (i_sts.err_zero) n_state = S_WSET;
                else n_state = S_WDIV_GO;
            end
            S_WDIV_GO:   n_state = S_WDIV_WAIT;
            S_WDIV_WAIT: if (!i_sts.div_busy) n_state = S_WSET;
            S_WSET:      n_state = S_MSQ_GO;
            S_MSQ_GO:    n_state = S_MSQ_WAIT;
            S_MSQ_WAIT:  if (!i_sts.mul_busy) n_state = S_ACC_SQ;
            S_ACC_SQ:    n_state = S_MDF_GO;
            S_MDF_GO:    n_state = S_MDF_WAIT;
            S_MDF_WAIT:  if (!i_sts.mul_busy) n_state = S_ACC_DF;
            S_ACC_DF:    n_state = S_LAST_CHK;
            S_LAST_CHK: begin
                if (!i_sts.last) n_state = S_IDLE;
                else if (i_sts.no_data) n_state = S_OUT;
                else n_state = S_FDIV_GO;
            end
            S_FDIV_GO:   n_state = S_FDIV_WAIT;
            S_FDIV_WAIT: if (!i_sts.div_busy) n_state = S_FMAG;
            S_FMAG:      n_state = S_MB_GO;
            S_MB_GO:     n_state = S_MB_WAIT;
            S_MB_WAIT:   if (!i_sts.mul_busy) n_state = S_BSET;
            S_BSET:      n_state = S_MC_GO;
            S_MC_GO:     n_state = S_MC_WAIT;
            S_MC_WAIT:   if (!i_sts.mul_busy) n_state = S_OUT;
            S_OUT:       if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.div_sel = DIV_W;
        o_cmd.mul_sel = MUL_SQ;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE:    o_cmd.load_in = i_in_valid;
            S_PREP:    o_cmd.prep = 1'b1;
            S_WDIV_GO: o_cmd.div_start = 1'b1;
            S_WSET:    o_cmd.set_w = 1'b1;
            S_MSQ_GO:  o_cmd.mul_start = 1'b1;
            S_ACC_SQ:  o_cmd.acc_sq = 1'b1;
            S_MDF_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_DF;
            end
            S_ACC_DF:  o_cmd.acc_df = 1'b1;
            S_FDIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_FIT;
            end
            S_FMAG:    o_cmd.fin_mag = 1'b1;
            S_MB_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_B;
            end
            S_BSET:    o_cmd.set_b = 1'b1;
            S_MC_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_C;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/wocf_dp.sv */
`timescale 1ns / 1ps
module wocf_dp
    import wocf_pkg::*;
#(
    parameter int MAG_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_in_item    i_in_data,
    input  logic        i_cfg_we,
    input  logic [22:0] i_cfg_wdata,
    output t_out_item   o_out_data
);

    localparam int SH1 = MAG_FRAC_BITS;
    localparam int SH2 = 2 * MAG_FRAC_BITS;

    logic [22:0]        r_thr;
    t_in_item           r_in;
    logic [47:0]        r_esq;
    logic [23:0]        r_dm;
    logic [47:0]        r_dm2;
    logic               r_dneg;
    logic [39:0]        r_w;
    logic [63:0]        r_s2;
    logic signed [63:0] r_sm;
    logic [63:0]        r_sw;
    logic [7:0]         r_cnt;
    logic [63:0]        r_num;
    logic               r_neg_sm;
    logic [23:0]        r_mag;
    logic [63:0]        r_a;
    t_out_item          r_out;

    // shift-add multiplier
    logic [127:0] r_ma, r_prod;
    logic [63:0]  r_mb;
    logic [5:0]   r_mcnt;
    logic         r_mbusy;
    t_mul_sel     r_msel;

    // restoring divider, dividend register collects the quotient
    logic [127:0] r_dv;
    logic [64:0]  r_rem;
    logic [63:0]  r_den;
    logic [6:0]   r_dcnt;
    logic         r_dbusy;

    logic signed [24:0] s_obs, s_thr, s_d;
    logic [63:0]  mul_a, mul_b, mulres, num_c, sq_sum, sw_sum, chi_diff;
    logic [127:0] shifted, div_dvd;
    logic [63:0]  div_den;
    logic [64:0]  rem_sh;
    logic         rem_ge;
    logic [39:0]  w_div;
    logic [23:0]  mag_lim, mag_q;
    logic signed [64:0] term, sm_sum;
    logic [47:0]  chi;

    assign s_obs = {r_in.obs_mag[23], r_in.obs_mag};
    assign s_thr = {2'b00, r_thr};
    assign s_d   = s_obs - {r_in.ref_mag[23], r_in.ref_mag};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQ:  begin mul_a = {24'b0, r_w}; mul_b = {16'b0, r_dm2}; end
            MUL_DF:  begin mul_a = {24'b0, r_w}; mul_b = {40'b0, r_dm}; end
            MUL_B:   begin mul_a = {16'b0, 48'(r_mag) * 48'(r_mag)}; mul_b = r_sw; end
            MUL_C:   begin mul_a = {39'b0, r_mag, 1'b0}; mul_b = r_num; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        if (r_msel == MUL_SQ || r_msel == MUL_B) shifted = r_prod >> SH2;
        else shifted = r_prod >> SH1;
        mulres = (|shifted[127:63]) ? SAT63 : shifted[63:0];
    end

    assign num_c = r_sm[63] ? 64'(-r_sm) : 64'(r_sm);

    always_comb begin
        if (i_cmd.div_sel == DIV_W) begin
            div_dvd = 128'(1) << (WT_FRAC + SH2);
            div_den = {16'b0, r_esq};
        end else begin
            div_dvd = {64'b0, num_c} << SH1;
            div_den = r_sw;
        end
    end

    assign rem_sh = {r_rem[63:0], r_dv[127]};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    assign w_div   = (|r_dv[127:40]) ? WT_MAX : r_dv[39:0];
    assign mag_lim = r_neg_sm ? MAG_NEG_LIM : MAG_POS_LIM;
    assign mag_q   = ((|r_dv[127:24]) || (r_dv[23:0] > mag_lim)) ? mag_lim : r_dv[23:0];

    assign sq_sum = r_s2 + mulres;
    assign sw_sum = r_sw + {24'b0, r_w};
    assign term   = r_dneg ? -$signed({1'b0, mulres}) : $signed({1'b0, mulres});
    assign sm_sum = $signed({r_sm[63], r_sm}) + term;

    assign chi_diff = r_a - mulres;
    assign chi = (r_a <= mulres) ? 48'd0 : ((chi_diff > OUT48) ? OUT48[47:0] : chi_diff[47:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_s2    <= '0;
            r_sm    <= '0;
            r_sw    <= '0;
            r_cnt   <= '0;
            r_mbusy <= 1'b0;
            r_dbusy <= 1'b0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            if (i_cmd.acc_sq) begin
                r_s2 <= sq_sum[63] ? SAT63 : sq_sum;
            end
            if (i_cmd.acc_df) begin
                if (sm_sum > $signed({1'b0, SAT63})) r_sm <= $signed(SAT63);
                else if (sm_sum < -$signed({1'b0, SAT63})) r_sm <= -$signed(SAT63);
                else r_sm <= sm_sum[63:0];
                r_sw <= sw_sum[63] ? SAT63 : sw_sum;
                if (r_cnt != 8'hFF) r_cnt <= r_cnt + 8'd1;
            end
            if (i_cmd.out_load) begin
                r_s2  <= '0;
                r_sm  <= '0;
                r_sw  <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && r_mcnt == 6'd63) begin
                r_mbusy <= 1'b0;
            end
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == 7'd127) begin
                r_dbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in_data;
        if (i_cmd.prep) begin
            r_esq  <= r_in.mag_error * r_in.mag_error;
            r_dm   <= s_d[24] ? 24'(-s_d) : s_d[23:0];
            r_dm2  <= (s_d[24] ? 24'(-s_d) : s_d[23:0]) * (s_d[24] ? 24'(-s_d) : s_d[23:0]);
            r_dneg <= s_d[24];
        end
        if (i_cmd.set_w) r_w <= o_sts.err_zero ? WT_ONE : w_div;
        if (i_cmd.mul_start) begin
            r_ma   <= {64'b0, mul_a};
            r_mb   <= mul_b;
            r_prod <= '0;
            r_mcnt <= '0;
            r_msel <= i_cmd.mul_sel;
        end else if (r_mbusy) begin
            if (r_mb[0]) r_prod <= r_prod + r_ma;
            r_ma   <= r_ma << 1;
            r_mb   <= r_mb >> 1;
            r_mcnt <= r_mcnt + 6'd1;
        end
        if (i_cmd.div_start) begin
            r_dv   <= div_dvd;
            r_den  <= div_den;
            r_rem  <= '0;
            r_dcnt <= '0;
            if (i_cmd.div_sel == DIV_FIT) begin
                r_num    <= num_c;
                r_neg_sm <= r_sm[63];
            end
        end else if (r_dbusy) begin
            r_rem  <= rem_ge ? rem_sh - {1'b0, r_den} : rem_sh;
            r_dv   <= {r_dv[126:0], rem_ge};
            r_dcnt <= r_dcnt + 7'd1;
        end
        if (i_cmd.fin_mag) r_mag <= mag_q;
        if (i_cmd.set_b) r_a <= r_s2 + mulres;
        if (i_cmd.out_load) begin
            r_out.used_filters <= r_cnt;
            if (o_sts.no_data) begin
                r_out.offset     <= '0;
                r_out.chi_square <= '0;
                r_out.no_data    <= 1'b1;
            end else begin
                r_out.offset     <= r_neg_sm ? $signed(-r_mag) : $signed(r_mag);
                r_out.chi_square <= chi;
                r_out.no_data    <= 1'b0;
            end
        end
    end

    assign o_sts.skip     = s_obs > s_thr;
    assign o_sts.err_zero = (r_in.mag_error == 24'd0);
    assign o_sts.last     = r_in.last_filter;
    assign o_sts.no_data  = (r_sw == 64'd0);
    assign o_sts.mul_busy = r_mbusy;
    assign o_sts.div_busy = r_dbusy;
    assign o_out_data     = r_out;

endmodule

/* rtl/weighted_offset_chisq_fit.sv */
// Sequential: one item at a time. A skipped filter goes straight to the last
// check; a used one runs the 128-step divider for the weight (not with zero
// error) and two 64-step shift-add multiplies. A last item adds the final divide
// and two multiplies. The result register frees the input side while it waits.
// Reset (synchronous, active low) clears sums, count and control; threshold = 50.0 mag.
`timescale 1ns / 1ps
module weighted_offset_chisq_fit
    import wocf_pkg::*;
#(
    parameter int MAG_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [22:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    wocf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wocf_dp #(.MAG_FRAC_BITS(MAG_FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/wocf_checker.sv */
`timescale 1ns / 1ps
module wocf_checker
    import wocf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("out valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_data |->
            o_out_data.offset == 24'sd0 && o_out_data.chi_square == 48'd0)
        else $error("no-data result carries values");

    a_empty_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.used_filters == 8'd0 |-> o_out_data.no_data)
        else $error("empty fit without no-data flag");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

endmodule

bind weighted_offset_chisq_fit wocf_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* tb/sv/wocf_fit_checker.sv */
`timescale 1ns / 1ps
module wocf_fit_checker
    import wocf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_we,
    input  logic [22:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);

    localparam int MAG_FRAC = 16;

    logic [22:0]        skip_thr;
    logic [63:0]        wsq_sum;
    logic signed [63:0] wdiff_sum;
    logic [63:0]        wt_sum;
    logic [7:0]         used_cnt;
    t_out_item          fit_q[$];
    int                 err_cnt;

    // floor(a*b / 2^sh), clipped to the 63-bit ceiling
    function automatic logic [63:0] mul_shift_sat(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> sh;
        if (p > {64'b0, SAT63})
            return SAT63;
        return p[63:0];
    endfunction

    function automatic logic [63:0] add_sat_u(logic [63:0] a, logic [63:0] b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        if (r > {1'b0, SAT63})
            return SAT63;
        return r[63:0];
    endfunction

    function automatic logic signed [63:0] add_sat_s(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [65:0] r;
        r = 66'(a) + 66'(b);
        if (r > 66'(signed'(SAT63)))
            return SAT63;
        if (r < -66'(signed'(SAT63)))
            return -signed'(SAT63);
        return r[63:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h", what, got, want);
        err_cnt++;
    endtask

    task automatic fit_filter(t_in_item it);
        int          obs_i, ref_i, d;
        logic [63:0] w, dm, e2, term, num, den, q, mag, lim, b, c, a;
        logic [127:0] quo;
        logic        neg;
        t_out_item   res;
        obs_i = int'($signed(it.obs_mag));
        ref_i = int'($signed(it.ref_mag));
        if (obs_i <= int'(skip_thr)) begin
            d = obs_i - ref_i;
            if (it.mag_error == 0) begin
                w = 64'(WT_ONE);
            end else begin
                e2 = 64'(it.mag_error) * 64'(it.mag_error);
                w = (64'd1 << (WT_FRAC + 2 * MAG_FRAC)) / e2;
                if (w > 64'(WT_MAX))
                    w = 64'(WT_MAX);
            end
            dm = (d < 0) ? 64'(-d) : 64'(d);
            wsq_sum = add_sat_u(wsq_sum, mul_shift_sat(w, dm * dm, 2 * MAG_FRAC));
            term = mul_shift_sat(w, dm, MAG_FRAC);
            wdiff_sum = add_sat_s(wdiff_sum, (d < 0) ? -signed'(term) : signed'(term));
            wt_sum = add_sat_u(wt_sum, w);
            if (used_cnt != 8'hFF)
                used_cnt++;
        end
        if (!it.last_filter)
            return;
        res = '0;
        res.used_filters = used_cnt;
        if (wt_sum == 0) begin
            res.no_data = 1'b1;
        end else begin
            neg = wdiff_sum < 0;
            num = neg ? 64'(-wdiff_sum) : 64'(wdiff_sum);
            den = wt_sum;
            q = num / den;
            lim = neg ? 64'(MAG_NEG_LIM) : 64'(MAG_POS_LIM);
            if (q >= (64'd1 << (24 - MAG_FRAC))) begin
                mag = lim;
            end else begin
                quo = ({64'b0, num} << MAG_FRAC) / {64'b0, den};
                mag = quo[63:0];
                if (mag > lim)
                    mag = lim;
            end
            b = mul_shift_sat(mag * mag, den, 2 * MAG_FRAC);
            c = mul_shift_sat(2 * mag, num, MAG_FRAC);
            a = wsq_sum + b;
            a = (a <= c) ? 64'd0 : a - c;
            if (a > OUT48)
                a = OUT48;
            res.offset = neg ? -mag[23:0] : mag[23:0];
            res.chi_square = a[47:0];
        end
        fit_q.push_back(res);
        wsq_sum = 0;
        wdiff_sum = 0;
        wt_sum = 0;
        used_cnt = 0;
    endtask

    task automatic check_fit(t_out_item got);
        t_out_item want;
        if (fit_q.size() == 0) begin
            report("unexpected result", 64'(got.chi_square), 64'd0);
            return;
        end
        want = fit_q.pop_front();
        if (got.offset !== want.offset)
            report("offset", 64'(got.offset), 64'(want.offset));
        if (got.chi_square !== want.chi_square)
            report("chi_square", 64'(got.chi_square), 64'(want.chi_square));
        if (got.used_filters !== want.used_filters)
            report("used_filters", 64'(got.used_filters), 64'(want.used_filters));
        if (got.no_data !== want.no_data)
            report("no_data", 64'(got.no_data), 64'(want.no_data));
    endtask

    initial begin
        err_cnt = 0;
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            skip_thr = THR_RESET;
            wsq_sum = 0;
            wdiff_sum = 0;
            wt_sum = 0;
            used_cnt = 0;
        end else begin
            if (i_cfg_we)
                skip_thr = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                fit_filter(i_in_data);
            if (i_out_valid && i_out_ready)
                check_fit(i_out_data);
        end
        o_errors <= err_cnt;
        o_pending <= fit_q.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import wocf_pkg::*;

    localparam int LONG_HOLD = 4000;
    localparam int IDLE_WAIT = 800;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [22:0] i_cfg_wdata;
    int          fail_cnt;
    int          pending;
    logic [22:0] cur_thr;
    int          n_items;
    int          n_fits;
    int          n_settings;
    bit          no_gap;
    int          cycles;

    weighted_offset_chisq_fit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    wocf_fit_checker u_fit_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (fail_cnt),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_in_item filt(int obs, int rf, int err, bit last);
        t_in_item it;
        it.obs_mag = obs[23:0];
        it.ref_mag = rf[23:0];
        it.mag_error = err[23:0];
        it.last_filter = last;
        return it;
    endfunction

    function automatic t_in_item rand_filter(logic [22:0] thr, bit last);
        int obs, rf, err, pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            obs = $urandom_range(0, 524288) - 262144;
        else if (pick < 80)
            obs = int'($signed(24'($urandom)));
        else if (pick < 90)
            obs = int'(thr) + $urandom_range(0, 1);
        else
            obs = $urandom_range(0, 1) ? 8388607 : -8388608;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            rf = obs + $urandom_range(0, 131072) - 65536;
        else
            rf = int'($signed(24'($urandom)));
        if (rf > 8388607) rf = 8388607;
        if (rf < -8388608) rf = -8388608;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            err = 0;
        else if (pick < 70)
            err = $urandom_range(1000, 200000);
        else if (pick < 85)
            err = $urandom_range(0, 16777215);
        else
            err = $urandom_range(1, 16);
        return filt(obs, rf, err, last);
    endfunction

    task automatic send(t_in_item it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            no_gap = ~no_gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        n_items++;
        if (it.last_filter)
            n_fits++;
    endtask

    // drain every result, then let a trailing unfinished filter settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [22:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_thr = v;
        n_settings++;
    endtask

    task automatic random_fits(int n);
        int left, len;
        left = n;
        while (left > 0) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                send(rand_filter(cur_thr, k == len - 1));
                left--;
            end
        end
    endtask

    // receiver: random stalls, one long hold after fifteen results
    initial begin
        int stall, got;
        got = 0;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 5);
            if (got == 15)
                stall = LONG_HOLD;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got++;
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        cur_thr = THR_RESET;
        n_items = 0;
        n_fits = 0;
        n_settings = 1;
        no_gap = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset threshold
        send(filt(0, 0, 0, 1));
        send(filt(3276800, -8388608, 1, 1));
        send(filt(3276801, 0, 0, 1));
        send(filt(-8388608, 8388607, 16777215, 0));
        send(filt(8388607, 0, 0, 0));
        send(filt(100000, 50000, 65536, 1));
        send(filt(-300000, 400000, 1, 0));
        send(filt(-200000, 100000, 3, 1));
        send(filt(65536, 65536, 0, 0));
        send(filt(65537, 65536, 16777215, 1));
        wait_idle();
        set_threshold(23'd0);
        send(filt(0, 12345, 7, 0));
        send(filt(1, 0, 0, 0));
        send(filt(-1, -1, 0, 1));
        send(filt(1, 0, 0, 1));
        wait_idle();
        set_threshold(23'h7FFFFF);
        send(filt(8388607, -8388608, 1, 1));
        send(filt(-8388608, 8388607, 1, 1));
        send(filt(8388607, 8388607, 0, 1));
        // long fit: count and square sum saturate
        for (int k = 0; k < 260; k++)
            send(filt(8388607, -8388608, $urandom_range(1, 3), k == 259));
        wait_idle();

        // random phases across threshold settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_threshold(THR_RESET);
                2: set_threshold(23'd0);
                default: set_threshold(23'($urandom_range(0, 8388607)));
            endcase
            random_fits(45);
            wait_idle();
        end

        $display("Covered %0d filter items in %0d fits over %0d threshold settings,",
                 n_items, n_fits, n_settings);
        $display("including saturating fits, skipped-only fits and long output stalls.");
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
